[hw/rtl/hwrl_pkg.sv]
// Package for the hopped-window RMS level meter.
// Holds shared constants, register indexes and the controller/datapath command and status types.
// Depends on nothing.
package hwrl_pkg;

   // Default values for the top-level parameters.
   localparam int WINDOW_MAX_DEFAULT  = 256;
   localparam int POWER_WIDTH_DEFAULT = 32;

   // Fixed field widths.
   localparam int POWER_PORT_WIDTH = 32;
   localparam int WINDOW_WIDTH     = 9;
   localparam int HOP_WIDTH        = 16;
   localparam int INDEX_WIDTH      = 32;
   localparam int LEVEL_WIDTH      = 16;
   localparam int SEEN_WIDTH       = 32;
   localparam int START_WIDTH      = 48;
   localparam int COUNT_WIDTH      = 7;
   localparam int CSR_DATA_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH  = 1;

   // Most items one input item may cause.
   localparam int MAX_RESULTS = 64;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_SAMPLES = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOP_SAMPLES    = 1'b1;

   // Register reset values.
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 9'd256;
   localparam logic [HOP_WIDTH-1:0]    HOP_RESET    = 16'd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;      // latch the input item, read the leaving sample
      logic update;      // update ring, sum and counters
      logic advance;     // step the hop phase
      logic lvl_sum;     // start a level on the running sum
      logic sum_start;   // start summing a flushed window from the ring
      logic lvl_acc;     // start a level on the flushed window sum
      logic take;        // store a finished level as a result
      logic finish;      // send the held result and close the item
   } hwrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic win_due;
      logic flush_more;
      logic sum_done;
      logic lvl_done;
      logic out_free;
      logic pend_valid;
      logic eor;
   } hwrl_status_type;

endpackage

[hw/rtl/hwrl_if.sv]
// Valid/ready channel interfaces for sample items and level items.
// Depends on hwrl_pkg for field widths.
interface hwrl_req_if
   import hwrl_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic [POWER_PORT_WIDTH-1:0] power;
   logic                        end_of_record;

   modport source (output valid, output power, output end_of_record, input ready);
   modport sink   (input valid, input power, input end_of_record, output ready);
endinterface

interface hwrl_rsp_if
   import hwrl_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [INDEX_WIDTH-1:0] window_index;
   logic [LEVEL_WIDTH-1:0] level;
   logic                   last;

   modport source (output valid, output window_index, output level, output last, input ready);
   modport sink   (input valid, input window_index, input level, input last, output ready);
endinterface

[hw/rtl/hwrl_level.sv]
// Level unit: serial divide of a window sum by the window length, then serial square root.
// Depends on hwrl_pkg.
module hwrl_level
   import hwrl_pkg::*;
#(
   parameter int SUM_WIDTH = 40
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [SUM_WIDTH-1:0]    operand,
   input  logic [WINDOW_WIDTH-1:0] divisor,
   output logic                    done,
   output logic [LEVEL_WIDTH-1:0]  level
);

   localparam int ROOT_WIDTH = (SUM_WIDTH + 1) / 2;
   localparam int SQ_WIDTH   = 2 * ROOT_WIDTH;
   localparam int CNT_WIDTH  = $clog2(SUM_WIDTH + 1);

   typedef enum logic [1:0] {LV_IDLE, LV_DIV, LV_SQRT} lv_state_type;

   lv_state_type            state_ff;
   logic                    done_ff;
   logic [CNT_WIDTH-1:0]    cnt_ff;
   logic [SUM_WIDTH-1:0]    quo_ff;
   logic [WINDOW_WIDTH-1:0] rem_ff;
   logic [WINDOW_WIDTH-1:0] div_ff;
   logic [SQ_WIDTH-1:0]     val_ff;
   logic [SQ_WIDTH-1:0]     root_ff;
   logic [SQ_WIDTH-1:0]     bit_ff;
   logic [LEVEL_WIDTH-1:0]  level_ff;

   logic [WINDOW_WIDTH:0]   trial;
   logic                    fits;
   logic [WINDOW_WIDTH:0]   trial_rem;
   logic [SQ_WIDTH:0]       cand;
   logic                    take;
   logic [SQ_WIDTH-1:0]     root_in;

   // One quotient bit per cycle.
   always_comb begin
      trial     = {rem_ff, quo_ff[SUM_WIDTH-1]};
      fits      = trial >= {1'b0, div_ff};
      trial_rem = fits ? (trial - {1'b0, div_ff}) : trial;
   end

   // One root bit per cycle.
   always_comb begin
      cand    = {1'b0, root_ff} + {1'b0, bit_ff};
      take    = {1'b0, val_ff} >= cand;
      root_in = take ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);
   end

   // Sequencer and registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LV_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         // Done pulses for one cycle after the last root bit.
         done_ff <= (state_ff == LV_SQRT) && (cnt_ff == CNT_WIDTH'(1));
         case (state_ff)
            LV_IDLE: begin
               if (start) begin
                  quo_ff   <= operand;
                  rem_ff   <= '0;
                  div_ff   <= divisor;
                  cnt_ff   <= CNT_WIDTH'(SUM_WIDTH);
                  state_ff <= LV_DIV;
               end
            end
            LV_DIV: begin
               quo_ff <= {quo_ff[SUM_WIDTH-2:0], fits};
               rem_ff <= trial_rem[WINDOW_WIDTH-1:0];
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_WIDTH'(1)) begin
                  state_ff <= LV_SQRT;
               end
            end
            LV_SQRT: begin
               if (cnt_ff == '0) begin
                  val_ff  <= SQ_WIDTH'(quo_ff);
                  root_ff <= '0;
                  bit_ff  <= SQ_WIDTH'(1) << (SQ_WIDTH - 2);
                  cnt_ff  <= CNT_WIDTH'(ROOT_WIDTH);
               end else begin
                  if (take) begin
                     val_ff <= val_ff - cand[SQ_WIDTH-1:0];
                  end
                  root_ff <= root_in;
                  bit_ff  <= bit_ff >> 2;
                  cnt_ff  <= cnt_ff - 1'b1;
                  if (cnt_ff == CNT_WIDTH'(1)) begin
                     if (root_in > SQ_WIDTH'({LEVEL_WIDTH{1'b1}})) begin
                        level_ff <= '1;
                     end else begin
                        level_ff <= root_in[LEVEL_WIDTH-1:0];
                     end
                     state_ff <= LV_IDLE;
                  end
               end
            end
            default: state_ff <= LV_IDLE;
         endcase
      end
   end

   assign done  = done_ff;
   assign level = level_ff;

endmodule

[hw/rtl/hwrl_datapath.sv]
// Datapath: sample ring, running sum, record counters, flush window summing,
// held result and output register. Depends on hwrl_pkg and hwrl_level.
module hwrl_datapath
   import hwrl_pkg::*;
#(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEFAULT,
   parameter int POWER_WIDTH = POWER_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hwrl_cmd_type                cmd,
   output hwrl_status_type             status,
   input  logic                        restart_req,
   input  logic [WINDOW_WIDTH-1:0]     window_reg,
   input  logic [HOP_WIDTH-1:0]        hop_reg,
   input  logic [POWER_PORT_WIDTH-1:0] in_power,
   input  logic                        in_eor,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [INDEX_WIDTH-1:0]      out_index,
   output logic [LEVEL_WIDTH-1:0]      out_level,
   output logic                        out_last
);

   localparam int PW      = (POWER_WIDTH < POWER_PORT_WIDTH) ? POWER_WIDTH : POWER_PORT_WIDTH;
   localparam int SW      = PW + 8;
   localparam int AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int DEPTH   = 1 << AW;

   // Sample ring.
   logic [PW-1:0] ring_mem [DEPTH];
   logic [PW-1:0] rd_ff;

   logic [PW-1:0]          item_power_ff;
   logic                   item_eor_ff;
   logic [AW-1:0]          pos_ff;
   logic [SW-1:0]          sum_ff;
   logic [SEEN_WIDTH-1:0]  seen_ff;
   logic [HOP_WIDTH-1:0]   phase_ff;
   logic [INDEX_WIDTH-1:0] wins_ff;
   logic [START_WIDTH-1:0] start_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [WINDOW_WIDTH-1:0] j_ff;
   logic [SW-1:0]          acc_ff;
   logic                   rdv_ff;
   logic                   summing_ff;
   logic                   pend_valid_ff;
   logic [INDEX_WIDTH-1:0] pend_idx_ff;
   logic [LEVEL_WIDTH-1:0] pend_level_ff;
   logic                   out_valid_ff;
   logic [INDEX_WIDTH-1:0] out_idx_ff;
   logic [LEVEL_WIDTH-1:0] out_level_ff;
   logic                   out_last_ff;

   logic [WINDOW_WIDTH-1:0] w_eff;
   logic [HOP_WIDTH-1:0]    hop_eff;
   logic                    full;
   logic [SW-1:0]           sum_in;
   logic [HOP_WIDTH:0]      phase_inc;
   logic [START_WIDTH:0]    end_v;
   logic [START_WIDTH:0]    n_ext;
   logic [WINDOW_WIDTH-1:0] over;
   logic [WINDOW_WIDTH+2:0] over5;
   logic [START_WIDTH:0]    idx;
   logic [SEEN_WIDTH:0]     n_twice;
   logic [AW-1:0]           src_lo;
   logic [AW-1:0]           slot_j;
   logic [AW-1:0]           slot_old;
   logic [AW-1:0]           rd_addr;
   logic                    rd_en;
   logic                    sum_issue;
   logic                    restart;
   logic                    push;
   logic                    lvl_done;
   logic [LEVEL_WIDTH-1:0]  lvl_level;

   // Effective window length and hop.
   always_comb begin
      if (window_reg == '0) begin
         w_eff = WINDOW_WIDTH'(1);
      end else if (window_reg > WINDOW_WIDTH'(WINDOW_MAX)) begin
         w_eff = WINDOW_WIDTH'(WINDOW_MAX);
      end else begin
         w_eff = window_reg;
      end
      hop_eff = (hop_reg == '0) ? HOP_WIDTH'(1) : hop_reg;
   end

   // Running sum and hop phase.
   always_comb begin
      full      = seen_ff >= SEEN_WIDTH'(w_eff);
      sum_in    = sum_ff - (full ? SW'(rd_ff) : '0) + SW'(item_power_ff);
      phase_inc = {1'b0, phase_ff} + 1'b1;
   end

   // Flush window limits: the window must start inside the record and
   // overrun the end by no more than a fifth of its length.
   always_comb begin
      n_ext = (START_WIDTH+1)'(seen_ff);
      end_v = {1'b0, start_ff} + (START_WIDTH+1)'(w_eff);
      over  = (end_v > n_ext) ? WINDOW_WIDTH'(end_v - n_ext) : '0;
      over5 = (WINDOW_WIDTH+3)'({over, 2'b00}) + (WINDOW_WIDTH+3)'(over);
   end

   // Ring slot of window sample j, reflected about the last sample.
   always_comb begin
      idx     = {1'b0, start_ff} + (START_WIDTH+1)'(j_ff);
      n_twice = {seen_ff, 1'b0};
      if (seen_ff <= SEEN_WIDTH'(1)) begin
         src_lo = '0;
      end else if (idx < n_ext) begin
         src_lo = idx[AW-1:0];
      end else begin
         src_lo = n_twice[AW-1:0] - AW'(2) - idx[AW-1:0];
      end
      slot_j    = pos_ff - seen_ff[AW-1:0] + src_lo;
      slot_old  = pos_ff - w_eff[AW-1:0];
      sum_issue = summing_ff && (j_ff < w_eff);
      rd_en     = cmd.accept || sum_issue;
      rd_addr   = cmd.accept ? slot_old : slot_j;
   end

   assign restart = restart_req || (cmd.finish && item_eor_ff);
   assign push    = (cmd.take && pend_valid_ff) || (cmd.finish && pend_valid_ff);

   // Ring memory with registered read.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ring_mem[pos_ff] <= item_power_ff;
      end
      if (rd_en) begin
         rd_ff <= ring_mem[rd_addr];
      end
   end

   // Item latch and record state.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_power_ff <= in_power[PW-1:0];
         item_eor_ff   <= in_eor;
      end
      if (reset || restart) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         seen_ff  <= '0;
         phase_ff <= '0;
         wins_ff  <= '0;
         start_ff <= '0;
      end else begin
         if (cmd.update) begin
            sum_ff <= sum_in;
            pos_ff <= pos_ff + 1'b1;
            if (seen_ff != '1) begin
               seen_ff <= seen_ff + 1'b1;
            end
         end
         if (cmd.advance && full) begin
            phase_ff <= (phase_inc >= {1'b0, hop_eff}) ? '0 : phase_inc[HOP_WIDTH-1:0];
         end
         if (cmd.take) begin
            wins_ff  <= wins_ff + 1'b1;
            start_ff <= start_ff + START_WIDTH'(hop_eff);
         end
      end
   end

   // Results caused by the current item.
   always_ff @(posedge clock) begin
      if (reset || cmd.accept) begin
         count_ff <= '0;
      end else if (cmd.take) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // Flushed window summing, one ring read per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         summing_ff <= 1'b0;
         rdv_ff     <= 1'b0;
      end else if (cmd.sum_start) begin
         summing_ff <= 1'b1;
         rdv_ff     <= 1'b0;
         j_ff       <= '0;
         acc_ff     <= '0;
      end else if (summing_ff) begin
         rdv_ff <= sum_issue;
         if (sum_issue) begin
            j_ff <= j_ff + 1'b1;
         end
         if (rdv_ff) begin
            acc_ff <= acc_ff + SW'(rd_ff);
         end
         if (!sum_issue && !rdv_ff) begin
            summing_ff <= 1'b0;
         end
      end
   end

   // Held result: sent once the next one exists or the item closes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.take) begin
         pend_valid_ff <= 1'b1;
         pend_idx_ff   <= wins_ff;
         pend_level_ff <= lvl_level;
      end else if (cmd.finish) begin
         pend_valid_ff <= 1'b0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (push) begin
         out_valid_ff <= 1'b1;
         out_idx_ff   <= pend_idx_ff;
         out_level_ff <= pend_level_ff;
         out_last_ff  <= cmd.finish && item_eor_ff;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   hwrl_level #(
      .SUM_WIDTH (SW)
   ) u_level (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.lvl_sum || cmd.lvl_acc),
      .operand (cmd.lvl_sum ? sum_ff : acc_ff),
      .divisor (w_eff),
      .done    (lvl_done),
      .level   (lvl_level)
   );

   // Status back to the controller.
   always_comb begin
      status.win_due    = full && (phase_ff == '0);
      status.flush_more = ({1'b0, start_ff} < n_ext)
                          && (over5 <= (WINDOW_WIDTH+3)'(w_eff))
                          && (count_ff < COUNT_WIDTH'(MAX_RESULTS));
      status.sum_done   = summing_ff && !sum_issue && !rdv_ff;
      status.lvl_done   = lvl_done;
      status.out_free   = !out_valid_ff || out_ready;
      status.pend_valid = pend_valid_ff;
      status.eor        = item_eor_ff;
   end

   assign out_valid = out_valid_ff;
   assign out_index = out_idx_ff;
   assign out_level = out_level_ff;
   assign out_last  = out_last_ff;

endmodule

[hw/rtl/hwrl_ctrl.sv]
// Controller: sequences one sample item through update, window level and record flush.
// Depends on hwrl_pkg.
module hwrl_ctrl
   import hwrl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  hwrl_status_type status,
   output hwrl_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RDOLD, ST_UPD, ST_CHK, ST_LVL_N, ST_EMIT_N,
      ST_FCHK, ST_FSUM, ST_LVL_F, ST_EMIT_F, ST_FIN
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           slot_ok;

   assign slot_ok  = !status.pend_valid || status.out_free;
   assign in_ready = (state_ff == ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_RDOLD;
            end
         end
         ST_RDOLD: state_in = ST_UPD;
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_CHK;
         end
         ST_CHK: begin
            cmd.advance = 1'b1;
            if (status.win_due) begin
               cmd.lvl_sum = 1'b1;
               state_in    = ST_LVL_N;
            end else begin
               state_in = status.eor ? ST_FCHK : ST_FIN;
            end
         end
         ST_LVL_N: begin
            if (status.lvl_done) begin
               state_in = ST_EMIT_N;
            end
         end
         ST_EMIT_N: begin
            if (slot_ok) begin
               cmd.take = 1'b1;
               state_in = status.eor ? ST_FCHK : ST_FIN;
            end
         end
         ST_FCHK: begin
            if (status.flush_more) begin
               cmd.sum_start = 1'b1;
               state_in      = ST_FSUM;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FSUM: begin
            if (status.sum_done) begin
               cmd.lvl_acc = 1'b1;
               state_in    = ST_LVL_F;
            end
         end
         ST_LVL_F: begin
            if (status.lvl_done) begin
               state_in = ST_EMIT_F;
            end
         end
         ST_EMIT_F: begin
            if (slot_ok) begin
               cmd.take = 1'b1;
               state_in = ST_FCHK;
            end
         end
         ST_FIN: begin
            if (slot_ok) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/hopped_window_rms_level.sv]
// Hopped-window RMS level meter. Each power item enters a ring of the last WINDOW_MAX
// samples and a running sum; when a window closes, level = isqrt(sum / W) is formed by a
// serial divider (one bit a cycle) and a serial square root (one root bit a cycle).
// An end_of_record item then flushes the pending windows, each summed from the ring's single
// read port before its level is formed; last marks the final level of the record.
// Configuration writes restart the record; the user must make them only while the block is
// idle, and the block itself does not enforce this.
module hopped_window_rms_level
   import hwrl_pkg::*;
#(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEFAULT,
   parameter int POWER_WIDTH = POWER_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   hwrl_req_if.sink                   req_ch,
   hwrl_rsp_if.source                 rsp_ch,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic [WINDOW_WIDTH-1:0] window_ff;
   logic [HOP_WIDTH-1:0]    hop_ff;
   hwrl_cmd_type            cmd;
   hwrl_status_type         status;
   logic                    in_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         hop_ff    <= HOP_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WINDOW_SAMPLES: window_ff <= csr_write_data[WINDOW_WIDTH-1:0];
            CSR_HOP_SAMPLES:    hop_ff    <= csr_write_data[HOP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign req_ch.ready = in_ready;

   hwrl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (in_ready),
      .status   (status),
      .cmd      (cmd)
   );

   hwrl_datapath #(
      .WINDOW_MAX  (WINDOW_MAX),
      .POWER_WIDTH (POWER_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .restart_req (csr_write_en),
      .window_reg  (window_ff),
      .hop_reg     (hop_ff),
      .in_power    (req_ch.power),
      .in_eor      (req_ch.end_of_record),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .out_index   (rsp_ch.window_index),
      .out_level   (rsp_ch.level),
      .out_last    (rsp_ch.last)
   );

endmodule

[verif/hwrl_level_checker.sv]
// Checker for the hopped-window RMS level meter: watches the sample, level and register ports.
// Predicts the level items of every accepted sample item and compares them in order.
// Depends on hwrl_pkg and the channel interfaces in hwrl_if.sv.
`timescale 1ns / 100ps
module hwrl_level_checker
   import hwrl_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   hwrl_req_if                        req_mon,
   hwrl_rsp_if                        rsp_mon,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                         mismatch_count,
   output int                         levels_pending
);

   typedef struct {
      logic [INDEX_WIDTH-1:0] window_index;
      logic [LEVEL_WIDTH-1:0] level;
      logic                   last;
   } level_item_type;

   // Predicted block state.
   logic [31:0]             history [256];
   logic [7:0]              write_slot;
   logic [63:0]             running_sum;
   logic [SEEN_WIDTH-1:0]   samples_in_record;
   logic [16:0]             hop_count;
   logic [INDEX_WIDTH-1:0]  next_window;
   logic [WINDOW_WIDTH-1:0] window_reg;
   logic [HOP_WIDTH-1:0]    hop_reg;
   level_item_type          levels_due[$];

   function automatic logic [63:0] int_sqrt(input logic [63:0] value);
      logic [63:0] root;
      logic [63:0] probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > value) probe = probe >> 2;
      while (probe != 0) begin
         if (value >= root + probe) begin
            value = value - (root + probe);
            root  = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic logic [LEVEL_WIDTH-1:0] rms_of(input logic [63:0] total,
                                                     input logic [8:0] length);
      logic [63:0] root;
      root = int_sqrt(total / length);
      return (root > 64'd65535) ? 16'hFFFF : root[15:0];
   endfunction

   // Reflect an index past the record end back into the record.
   function automatic logic [63:0] reflect(input logic [63:0] idx, input logic [63:0] n);
      logic [63:0] period;
      if (n <= 1) return 0;
      period = 2 * (n - 1);
      idx    = idx % period;
      return (idx < n) ? idx : period - idx;
   endfunction

   task automatic restart_record();
      write_slot        = 0;
      running_sum       = 0;
      samples_in_record = 0;
      hop_count         = 0;
      next_window       = 0;
   endtask

   // Advance the predicted state by one sample item and queue the levels it produces.
   task automatic take_sample(input logic [31:0] power, input logic eor);
      logic [8:0]        win;
      logic [63:0]       hop;
      logic [63:0]       n;
      logic [63:0]       start;
      logic [63:0]       stop;
      logic [63:0]       over;
      logic [63:0]       total;
      logic [63:0]       src;
      logic [31:0]       k;
      level_item_type    fresh[$];
      level_item_type    entry;
      win = (window_reg == 0) ? 9'd1 : ((window_reg > 256) ? 9'd256 : window_reg);
      hop = (hop_reg == 0) ? 64'd1 : 64'(hop_reg);
      if (samples_in_record >= win)
         running_sum = running_sum - history[8'(write_slot - win[7:0])];
      history[write_slot] = power;
      running_sum = running_sum + power;
      write_slot  = write_slot + 8'd1;
      if (samples_in_record != '1) samples_in_record = samples_in_record + 1;

      // A window closes on this sample when the hop phase is at zero.
      if (samples_in_record >= win) begin
         if (hop_count == 0) begin
            entry = '{next_window, rms_of(running_sum, win), 1'b0};
            fresh.insert(fresh.size(), entry);
            next_window = next_window + 1;
         end
         hop_count = hop_count + 1;
         if (hop_count >= hop) hop_count = 0;
      end

      // End of record: flush windows that start inside it, mirroring past the end.
      if (eor) begin
         n = 64'(samples_in_record);
         k = next_window;
         while (fresh.size() < MAX_RESULTS) begin
            start = 64'(k) * hop;
            if (start >= n) break;
            stop = start + win;
            over = (stop > n) ? stop - n : 0;
            if (over * 5 > win) break;
            total = 0;
            for (int j = 0; j < win; j++) begin
               src   = reflect(start + j, n);
               total = total + history[8'(write_slot - 8'(n - src))];
            end
            entry = '{k, rms_of(total, win), 1'b0};
            fresh.insert(fresh.size(), entry);
            k = k + 1;
         end
         if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
         restart_record();
      end
      foreach (fresh[i]) levels_due.insert(levels_due.size(), fresh[i]);
   endtask

   always @(posedge clock) begin
      level_item_type want;
      if (reset) begin
         window_reg     = WINDOW_RESET;
         hop_reg        = HOP_RESET;
         mismatch_count = 0;
         levels_due.delete();
         restart_record();
      end else begin
         // Register writes take effect at once and restart the record.
         if (csr_write_en) begin
            if (csr_index == CSR_WINDOW_SAMPLES) window_reg = csr_write_data[WINDOW_WIDTH-1:0];
            else if (csr_index == CSR_HOP_SAMPLES) hop_reg = csr_write_data[HOP_WIDTH-1:0];
            restart_record();
         end
         if (req_mon.valid && req_mon.ready) take_sample(req_mon.power, req_mon.end_of_record);

         // Compare each accepted level item with the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (levels_due.size() == 0) begin
               $error("unexpected level item: window_index %0d level %0d last %0d",
                      rsp_mon.window_index, rsp_mon.level, rsp_mon.last);
               mismatch_count++;
            end else begin
               want = levels_due.pop_front();
               if (rsp_mon.window_index !== want.window_index) begin
                  $error("window_index: expected %0d, actual %0d",
                         want.window_index, rsp_mon.window_index);
                  mismatch_count++;
               end
               if (rsp_mon.level !== want.level) begin
                  $error("level: expected %0d, actual %0d", want.level, rsp_mon.level);
                  mismatch_count++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_mon.last);
                  mismatch_count++;
               end
            end
         end
      end
      levels_pending <= levels_due.size();
   end

endmodule

[verif/hopped_window_rms_level_tb.sv]
// Testbench top for the hopped-window RMS level meter: clock, reset, sample stimulus,
// register writes and receiver stalls; the verdict comes from hwrl_level_checker.
// Depends on hwrl_pkg, hwrl_if.sv, the block and the checker.
`timescale 1ns / 100ps
module hopped_window_rms_level_tb;
   import hwrl_pkg::*;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;
   int                         mismatch_count;
   int                         levels_pending;
   int                         tx_idle_pct = 30;
   int                         rx_idle_pct = 59;
   int                         levels_taken = 0;
   int                         hold_left = 0;
   logic                       hold_done = 1'b0;

   hwrl_req_if req_ch ();
   hwrl_rsp_if rsp_ch ();

   hopped_window_rms_level i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   hwrl_level_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .levels_pending (levels_pending)
   );

   always #5 clock = ~clock;

   // Receiver: random stalls, plus one long hold-off that starts while a sample item is
   // offered once twenty level items have been taken.
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready) levels_taken <= levels_taken + 1;
      if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (levels_taken >= 20 && req_ch.valid && !hold_done) begin
         hold_left    <= 3000;
         hold_done    <= 1'b1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Offer one sample item and hold it until accepted.
   task automatic send_sample(input logic [31:0] power, input logic eor);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.power         <= power;
      req_ch.end_of_record <= eor;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Wait until every predicted level item has arrived and the block has settled.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (levels_pending != 0);
      repeat (400) @(posedge clock);
   endtask

   // One register write; the enable is then dropped before the task returns.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_power();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int win;
      int len;
      int phase_items;
      req_ch.valid         <= 1'b0;
      req_ch.power         <= '0;
      req_ch.end_of_record <= 1'b0;
      csr_write_en         <= 1'b0;
      csr_index            <= CSR_WINDOW_SAMPLES;
      csr_write_data       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default window of 256: a short record ends with nothing to emit.
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0, 1'b0);
      send_sample(32'h1, 1'b1);
      wait_idle();

      // Window 10, hop 3: one window in the record, one flushed with mirrored samples.
      write_reg(CSR_WINDOW_SAMPLES, 16'd10);
      write_reg(CSR_HOP_SAMPLES, 16'd3);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h5555_5555, 1'b0);
      send_sample(32'hAAAA_AAAA, 1'b0);
      for (int i = 0; i < 4; i++) send_sample($urandom, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b1);
      wait_idle();

      // Window 0 acts as 1: end of record on the very first sample.
      write_reg(CSR_WINDOW_SAMPLES, 16'd0);
      send_sample(32'hFFFF_FFFF, 1'b1);
      wait_idle();

      // Window above the maximum and zero hop; unused data bits set.
      write_reg(CSR_WINDOW_SAMPLES, 16'hFFFF);
      write_reg(CSR_HOP_SAMPLES, 16'd0);
      send_sample(32'h1234_5678, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b1);
      wait_idle();

      // Largest hop: only the first window ever closes.
      write_reg(CSR_WINDOW_SAMPLES, 16'd2);
      write_reg(CSR_HOP_SAMPLES, 16'hFFFF);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0, 1'b1);
      wait_idle();

      // Random phases: mostly complete records with random content.
      for (int phase = 0; phase < 8; phase++) begin
         tx_idle_pct = (phase < 3) ? 30 : ((phase < 6) ? 59 : 0);
         rx_idle_pct = (phase < 3) ? 59 : ((phase < 6) ? 30 : 0);
         if (phase == 4) begin
            // Long window whose flush needs mirrored samples.
            write_reg(CSR_WINDOW_SAMPLES, {7'($urandom), 9'd128});
            write_reg(CSR_HOP_SAMPLES, 16'd16);
            for (int i = 0; i < 110; i++) send_sample(random_power(), i == 109);
         end else begin
            win = $urandom_range(1, 24);
            write_reg(CSR_WINDOW_SAMPLES, {7'($urandom), 9'(win)});
            write_reg(CSR_HOP_SAMPLES, ($urandom_range(0, 5) == 0) ?
                      16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 8)));
            phase_items = 0;
            while (phase_items < 12) begin
               len = $urandom_range(1, 2 * win + 8);
               for (int i = 0; i < len; i++)
                  send_sample(random_power(),
                              (i == len - 1) && ($urandom_range(0, 7) != 0));
               phase_items += len;
            end
         end
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #400_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[hopped_window_rms_level.f]
hw/rtl/hwrl_pkg.sv
hw/rtl/hwrl_if.sv
hw/rtl/hwrl_level.sv
hw/rtl/hwrl_datapath.sv
hw/rtl/hwrl_ctrl.sv
hw/rtl/hopped_window_rms_level.sv
verif/hwrl_level_checker.sv
verif/hopped_window_rms_level_tb.sv
